/* src/indexed_min_heap_queue_assert.svh */
// Assertion macros shared by the heap queue modules.
`ifndef INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH
// Property that holds in the clock after the antecedent.
`define IMHQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// Property that holds in the same clock as the antecedent.
`define IMHQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

/* src/imhq_pkg.sv */
// Package with types, constants and command structs of the heap queue.
`timescale 1ns / 1ps
package imhq_pkg;
  localparam int Capacity = 256;
  localparam int KeyBits = 32;
  localparam int IdCount = 256;
  localparam int SlotBits = $clog2(Capacity + 1);
  localparam int AddrBits = $clog2(Capacity + 1);
  localparam int IdBits = 8;
  localparam int EntryBits = IdBits + KeyBits;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_LOWERED = 3'd1;
  localparam logic [2:0] ST_UNCHANGED = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  typedef struct packed {
    logic operation;
    logic [7:0] element_id;
    logic [31:0] priority_key;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] top_id;
    logic [31:0] top_key;
    logic queue_empty;
    logic [8:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [IdBits-1:0] id;
    logic [KeyBits-1:0] key;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_DECIDE, S_PLACE,
    S_DN_RD, S_DN_RD2, S_DN_CMP, S_UP_RD, S_UP_CMP,
    S_PUT, S_TOP_RD, S_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;        // latch request and look up position map
    logic rd_slot;        // read heap slot given by the position map
    logic rd_last;        // read last slot
    logic rd_left;        // read left child of cur
    logic rd_right;       // read right child of cur, latch left child
    logic rd_parent;      // read parent of cur
    logic rd_top;         // read slot 1
    logic do_insert;      // grow and start sift-up at the new slot
    logic do_lower;       // start sift-up at the looked-up slot
    logic do_remove;      // clear presence, shrink, take last entry
    logic dn_step;        // move chosen child up into cur
    logic up_step;        // move parent down into cur
    logic put_ent;        // write moving entry at cur
    logic [2:0] status;
    logic finish;         // build response
  } cmd_t;

  typedef struct packed {
    logic present;
    logic full;
    logic lower;
    logic last_removed;   // removed slot was the last slot
    logic has_child;
    logic dn_move;
    logic at_root;
    logic up_move;
    logic out_free;       // response register can take a new response
  } sts_t;
endpackage

/* src/imhq_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
module imhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/imhq_ctrl.sv */
// Controller state machine sequencing lookups, sifts and responses.
`timescale 1ns / 1ps
`include "indexed_min_heap_queue_assert.svh"
module imhq_ctrl import imhq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   is_remove,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);
  state_t state, state_next;
  logic [2:0] status, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      status <= ST_INSERTED;
    end else begin
      state <= state_next;
      status <= status_next;
    end
  end

  always_comb begin
    state_next = state;
    status_next = status;
    cmd = '0;
    cmd.status = status;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.rd_slot = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!is_remove) begin
          if (!sts.present) begin
            if (sts.full) begin
              status_next = ST_FULL;
              state_next = S_TOP_RD;
            end else begin
              cmd.do_insert = 1'b1;
              status_next = ST_INSERTED;
              state_next = S_UP_RD;
            end
          end else if (sts.lower) begin
            cmd.do_lower = 1'b1;
            status_next = ST_LOWERED;
            state_next = S_UP_RD;
          end else begin
            status_next = ST_UNCHANGED;
            state_next = S_TOP_RD;
          end
        end else if (!sts.present) begin
          status_next = ST_ABSENT;
          state_next = S_TOP_RD;
        end else begin
          cmd.rd_last = 1'b1;
          status_next = ST_REMOVED;
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.do_remove = 1'b1;
        state_next = sts.last_removed ? S_TOP_RD : S_DN_RD;
      end
      S_DN_RD: begin
        if (sts.has_child) begin
          cmd.rd_left = 1'b1;
          state_next = S_DN_RD2;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_DN_RD2: begin
        cmd.rd_right = 1'b1;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_move) begin
          cmd.dn_step = 1'b1;
          state_next = S_DN_RD;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (sts.at_root) begin
          state_next = S_PUT;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_move) begin
          cmd.up_step = 1'b1;
          state_next = S_UP_RD;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put_ent = 1'b1;
        state_next = S_TOP_RD;
      end
      S_TOP_RD: begin
        cmd.rd_top = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // Keep slot 1 on the read port while the response register is busy.
        cmd.rd_top = 1'b1;
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `IMHQ_ASSERT_NOW(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `IMHQ_ASSERT_NEXT(a_cap_lookup, clk, rst, cmd.capture, state == S_LOOKUP)
  `IMHQ_ASSERT_NEXT(a_finish_idle, clk, rst, cmd.finish, state == S_IDLE)
endmodule

/* src/imhq_dp.sv */
// Datapath: heap memory, position map, sift registers and response register.
`timescale 1ns / 1ps
`include "indexed_min_heap_queue_assert.svh"
module imhq_dp import imhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic is_remove,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);
  // Request registers.
  logic op;
  logic [IdBits-1:0] rid;
  logic [KeyBits-1:0] rkey;
  logic [SlotBits-1:0] size;
  logic [SlotBits-1:0] cur;      // slot of the moving entry
  logic [SlotBits-1:0] pos_slot; // looked-up map slot
  entry_t ent;                   // moving entry, kept in registers
  entry_t lft;                   // left child
  logic rsp_pend;
  rsp_t rsp_q;

  // Presence bits in flops; slot numbers in the map memory.
  logic [IdCount-1:0] map_valid;

  logic heap_we;
  logic [SlotBits-1:0] heap_wa, heap_ra;
  entry_t heap_wd, heap_rd;

  logic map_we;
  logic [IdBits-1:0] map_wa, map_ra;
  logic [SlotBits-1:0] map_wd, map_rd;

  imhq_ram #(.Width(EntryBits), .Depth(2 ** AddrBits)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
    .raddr(heap_ra), .rdata(heap_rd)
  );

  imhq_ram #(.Width(SlotBits), .Depth(IdCount)) u_map (
    .clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
    .raddr(map_ra), .rdata(map_rd)
  );

  logic [SlotBits:0] left_wide, right_wide;
  logic [SlotBits-1:0] left_slot, right_slot, parent_slot, kid_slot;
  logic has_right, pick_right;
  entry_t kid;

  assign parent_slot = cur >> 1;
  assign left_wide = {cur, 1'b0};
  assign right_wide = {cur, 1'b1};
  assign left_slot = left_wide[SlotBits-1:0];
  assign right_slot = right_wide[SlotBits-1:0];
  assign has_right = right_wide <= {1'b0, size};
  // The left child wins ties; in the compare state the right child is on the read port.
  assign pick_right = has_right && (lft.key > heap_rd.key);
  assign kid = pick_right ? heap_rd : lft;
  assign kid_slot = pick_right ? right_slot : left_slot;

  assign is_remove = op;
  assign map_ra = cmd.capture ? req.element_id : rid;

  always_comb begin
    sts = '0;
    sts.present = map_valid[rid];
    sts.full = size == SlotBits'(Capacity);
    sts.lower = rkey < heap_rd.key;
    sts.last_removed = pos_slot == size;
    sts.has_child = left_wide <= {1'b0, size};
    sts.dn_move = kid.key < ent.key;
    sts.at_root = cur == SlotBits'(1);
    sts.up_move = heap_rd.key > ent.key;
    sts.out_free = !rsp_pend || rsp_ready;
  end

  // The moving entry stays in registers and is written once the sift ends.
  always_comb begin
    heap_ra = cur;
    if (cmd.rd_slot) heap_ra = map_rd;
    if (cmd.rd_last) heap_ra = size;
    if (cmd.rd_left) heap_ra = left_slot;
    if (cmd.rd_right) heap_ra = right_slot;
    if (cmd.rd_parent) heap_ra = parent_slot;
    if (cmd.rd_top) heap_ra = SlotBits'(1);

    heap_we = 1'b0;
    heap_wa = cur;
    heap_wd = ent;
    map_we = 1'b0;
    map_wa = ent.id;
    map_wd = cur;
    if (cmd.dn_step) begin
      heap_we = 1'b1;
      heap_wd = kid;
      map_we = 1'b1;
      map_wa = kid.id;
    end
    if (cmd.up_step) begin
      heap_we = 1'b1;
      heap_wd = heap_rd;
      map_we = 1'b1;
      map_wa = heap_rd.id;
    end
    if (cmd.put_ent) begin
      heap_we = 1'b1;
      map_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= '0;
      map_valid <= '0;
      rsp_pend <= 1'b0;
    end else begin
      if (cmd.finish) rsp_pend <= 1'b1;
      else if (rsp_ready) rsp_pend <= 1'b0;
      if (cmd.capture) begin
        op <= req.operation;
        rid <= req.element_id;
        rkey <= req.priority_key[KeyBits-1:0];
      end
      if (cmd.rd_slot) pos_slot <= map_rd;
      if (cmd.do_insert) begin
        size <= size + SlotBits'(1);
        cur <= size + SlotBits'(1);
        ent <= '{id: rid, key: rkey};
        map_valid[rid] <= 1'b1;
      end
      if (cmd.do_lower) begin
        cur <= pos_slot;
        ent <= '{id: rid, key: rkey};
      end
      if (cmd.do_remove) begin
        size <= size - SlotBits'(1);
        map_valid[rid] <= 1'b0;
        cur <= pos_slot;
        ent <= heap_rd;
      end
      if (cmd.rd_right) lft <= heap_rd;
      if (cmd.dn_step) cur <= kid_slot;
      if (cmd.up_step) cur <= parent_slot;
      if (cmd.finish) begin
        rsp_q.status <= cmd.status;
        rsp_q.entry_count <= size;
        rsp_q.queue_empty <= size == '0;
        rsp_q.top_id <= size == '0 ? '0 : heap_rd.id;
        rsp_q.top_key <= size == '0 ? '0 : heap_rd.key;
      end
    end
  end

  assign rsp_valid = rsp_pend;
  assign rsp = rsp_q;

  `IMHQ_ASSERT_NOW(a_size_cap, clk, rst, 1'b1, size <= SlotBits'(Capacity))
  `IMHQ_ASSERT_NEXT(a_ins_grow, clk, rst, cmd.do_insert, size == $past(size) + SlotBits'(1))
  `IMHQ_ASSERT_NEXT(a_rem_shrink, clk, rst, cmd.do_remove, size == $past(size) - SlotBits'(1))
endmodule

/* src/indexed_min_heap_queue.sv */
// Top level of the indexed min-heap priority queue.
//   channel | direction | handshake
//   in      | request   | in_valid / in_ready
//   out     | result    | out_valid / out_ready
// From acceptance to result a request is looked up, sifted up or down one level at a
// time where it changes the heap, and the new top is read; every step is set by the
// single read port of the heap memory.
// Reset is synchronous and empties the queue. While a result waits in the output
// register the next request is processed; it then holds in its last state, and the
// input stalls, until the register is free.
`timescale 1ns / 1ps
module indexed_min_heap_queue import imhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);
  cmd_t cmd;
  sts_t sts;
  logic is_remove;

  imhq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .is_remove(is_remove),
    .in_ready(in_ready), .sts(sts), .cmd(cmd)
  );

  imhq_dp u_dp (
    .clk(clk), .rst(rst), .req(in_data), .cmd(cmd), .sts(sts),
    .is_remove(is_remove), .rsp_valid(out_valid), .rsp_ready(out_ready),
    .rsp(out_data)
  );
endmodule

/* tb/indexed_min_heap_queue_test.sv */
// Testbench for the indexed min-heap priority queue: directed and random requests.
`timescale 1ns / 1ps
module indexed_min_heap_queue_test;
  import imhq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  indexed_min_heap_queue DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the heap and its position map.
  logic [IdBits-1:0] shadow_id [1:Capacity];
  logic [KeyBits-1:0] shadow_key [1:Capacity];
  int shadow_slot [IdCount];
  int shadow_size;

  rsp_t pending_results[$];
  int error_count = 0;
  int result_count = 0;
  int status_seen [6];
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_cycles = 0;
  logic long_hold = 1'b0;
  event long_hold_go;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch #%0d on result %0d: %s got %0h expected %0h",
             error_count, result_count, what, got, want);
    error_count++;
  endtask

  function automatic void place_entry(input int s, input logic [7:0] id,
                                      input logic [31:0] key);
    shadow_id[s] = id;
    shadow_key[s] = key;
    shadow_slot[id] = s;
  endfunction

  function automatic void swap_entries(input int a, input int b);
    logic [7:0] ia;
    logic [31:0] ka;
    ia = shadow_id[a];
    ka = shadow_key[a];
    place_entry(a, shadow_id[b], shadow_key[b]);
    place_entry(b, ia, ka);
  endfunction

  function automatic int bubble_up(input int start);
    int s;
    s = start;
    while (s > 1 && shadow_key[s/2] > shadow_key[s]) begin
      swap_entries(s/2, s);
      s = s / 2;
    end
    return s;
  endfunction

  function automatic int bubble_down(input int start);
    int s;
    int c;
    s = start;
    forever begin
      c = 2 * s;
      if (c > shadow_size) break;
      if (c + 1 <= shadow_size && shadow_key[c] > shadow_key[c+1]) c++;
      if (shadow_key[c] < shadow_key[s]) begin
        swap_entries(c, s);
        s = c;
      end else break;
    end
    return s;
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    int s;
    logic [7:0] lid;
    logic [31:0] lkey;
    s = shadow_slot[r.element_id];
    if (s > shadow_size) s = 0;
    o = '0;
    if (r.operation == OP_INSERT) begin
      if (s == 0) begin
        if (shadow_size >= Capacity) o.status = ST_FULL;
        else begin
          shadow_size++;
          place_entry(shadow_size, r.element_id, r.priority_key);
          void'(bubble_up(shadow_size));
          o.status = ST_INSERTED;
        end
      end else if (r.priority_key < shadow_key[s]) begin
        shadow_key[s] = r.priority_key;
        void'(bubble_up(s));
        o.status = ST_LOWERED;
      end else o.status = ST_UNCHANGED;
    end else begin
      if (s == 0) o.status = ST_ABSENT;
      else begin
        lid = shadow_id[shadow_size];
        lkey = shadow_key[shadow_size];
        shadow_slot[r.element_id] = 0;
        shadow_size--;
        if (s <= shadow_size) begin
          place_entry(s, lid, lkey);
          s = bubble_down(s);
          void'(bubble_up(s));
        end
        o.status = ST_REMOVED;
      end
    end
    if (shadow_size == 0) o.queue_empty = 1'b1;
    else begin
      o.top_id = shadow_id[1];
      o.top_key = shadow_key[1];
    end
    o.entry_count = shadow_size[8:0];
    return o;
  endfunction

  // Valid stays high after acceptance only when the next request follows at once.
  task automatic send_request(input logic op, input logic [7:0] id,
                              input logic [31:0] key);
    req_t r;
    r.operation = op;
    r.element_id = id;
    r.priority_key = key;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(r));
  endtask

  // Long receiver hold, counted here and seen by the ready driver.
  initial begin
    forever begin
      @(long_hold_go);
      long_hold <= 1'b1;
      repeat (400) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  // Ready driver: random short stalls while receiver_idles is set, ready low during a long hold.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (long_hold) out_ready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      hold_cycles <= $urandom_range(0, 2);
    end else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0)
        report_mismatch("unexpected result", 1, 0);
      else begin
        want = pending_results.pop_front();
        if (out_data.status <= ST_FULL) status_seen[out_data.status]++;
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
        if (out_data.top_id !== want.top_id)
          report_mismatch("top_id", int'(out_data.top_id), int'(want.top_id));
        if (out_data.top_key !== want.top_key)
          report_mismatch("top_key", int'(out_data.top_key), int'(want.top_key));
        if (out_data.queue_empty !== want.queue_empty)
          report_mismatch("queue_empty", int'(out_data.queue_empty),
                          int'(want.queue_empty));
        if (out_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", int'(out_data.entry_count),
                          int'(want.entry_count));
      end
      result_count++;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(OP_REMOVE, 8'd7, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 8'd0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 8'd255, 32'h0000_0000);
    send_request(OP_INSERT, 8'd10, 32'h0000_0000);
    send_request(OP_INSERT, 8'd11, 32'h0001_0000);
    send_request(OP_INSERT, 8'd12, 32'h0001_0000);
    send_request(OP_INSERT, 8'd11, 32'h0001_0000);
    send_request(OP_INSERT, 8'd11, 32'hAAAA_5555);
    send_request(OP_INSERT, 8'd0, 32'h8000_0000);
    send_request(OP_INSERT, 8'd12, 32'h0000_0000);
    send_request(OP_REMOVE, 8'd255, 32'h5555_AAAA);
    send_request(OP_REMOVE, 8'd255, 32'h0);
    send_request(OP_REMOVE, 8'd12, 32'h0);
    send_request(OP_REMOVE, 8'd11, 32'h0);
    send_request(OP_REMOVE, 8'd0, 32'h0);
    send_request(OP_REMOVE, 8'd10, 32'h0);
    wait_drained();
  endtask

  // Start a long output hold, fill to capacity, probe the full heap, then remove random ids.
  task automatic test_full_heap();
    -> long_hold_go;
    for (int i = 0; i < Capacity; i++)
      send_request(OP_INSERT, i[7:0], $urandom_range(0, 40));
    send_request(OP_INSERT, 8'd3, 32'h0);
    send_request(OP_REMOVE, 8'd128, 32'h0);
    send_request(OP_INSERT, 8'd128, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 8'd128, 32'h0);
    for (int i = 0; i < Capacity; i++)
      send_request(OP_REMOVE, 8'($urandom_range(0, 255)), 32'h0);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int id_span);
    logic [31:0] key;
    for (int i = 0; i < count; i++) begin
      key = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64);
      send_request($urandom_range(0, 99) < 40, 8'($urandom_range(0, id_span)), key);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_heap();
    test_random(300, 255);
    test_random(300, 31);
    wait_drained();
    test_random(150, 7);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random(250, 255);
    wait_drained();
    repeat (100) @(posedge clk);
    $display("covered %0d results: inserted %0d, lowered %0d, unchanged %0d,",
             result_count, status_seen[ST_INSERTED], status_seen[ST_LOWERED],
             status_seen[ST_UNCHANGED]);
    $display("  removed %0d, absent removes %0d, full inserts %0d",
             status_seen[ST_REMOVED], status_seen[ST_ABSENT], status_seen[ST_FULL]);
    if (error_count == 0 && pending_results.size() == 0)
      $display("indexed_min_heap_queue_test: PASS");
    else
      $display("indexed_min_heap_queue_test: FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("indexed_min_heap_queue_test: FAIL");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/imhq_pkg.sv
src/imhq_ram.sv
src/imhq_ctrl.sv
src/imhq_dp.sv
src/indexed_min_heap_queue.sv
tb/indexed_min_heap_queue_test.sv
